// ===== rtl/trst_pkg.sv =====
// ----------------------------------------------------------------------------
// trst_pkg
// Shared types and constants for the touch report slot tracker.
// ----------------------------------------------------------------------------
package trst_pkg;

  localparam int REPORT_BYTES = 24;
  localparam int SLOT_COUNT   = 5;

  localparam int POS_W   = $clog2(REPORT_BYTES);
  localparam int CNT_W   = $clog2(SLOT_COUNT + 1);
  localparam int IDX_W   = POS_W - 2;
  localparam int SLOT_W  = 3;
  localparam int COORD_W = 12;
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);

  localparam logic [POS_W-1:0] LAST_POS = POS_W'(REPORT_BYTES - 1);

  typedef enum logic [1:0] {
    KIND_PRESS   = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_SYNC    = 2'd2
  } kind_t;

  typedef logic [SLOT_COUNT-1:0] slot_mask_t;

  // One entry of work per input byte that causes events.
  typedef struct packed {
    logic                press;
    logic [SLOT_W-1:0]   slot;
    logic [COORD_W-1:0]  x;
    logic [COORD_W-1:0]  y;
    slot_mask_t          rel;
    logic                sync;
  } cmd_t;

  // Index of the lowest set bit (0 when empty).
  function automatic logic [SLOT_W-1:0] low_slot(slot_mask_t m);
    logic [SLOT_W-1:0] s;
    s = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (m[i]) s = SLOT_W'(i);
    end
    return s;
  endfunction

  // Mask with only the lowest set bit cleared.
  function automatic slot_mask_t drop_low(slot_mask_t m);
    return m & (m - slot_mask_t'(1));
  endfunction

endpackage

// ===== rtl/trst_front.sv =====
// ----------------------------------------------------------------------------
// trst_front
// Report parser: tracks byte position and slot sets, builds event work.
// ----------------------------------------------------------------------------
module trst_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  logic [7:0]    report_byte,
  input  logic          frame_start,
  output logic          push,
  output trst_pkg::cmd_t cmd
);
  import trst_pkg::*;

  logic [POS_W-1:0]  byte_pos_r, byte_pos_nxt;
  logic [CNT_W-1:0]  touch_cnt_r, touch_cnt_nxt;
  logic [23:0]       pt_bytes_r, pt_bytes_nxt;
  slot_mask_t        cur_r, cur_nxt;
  slot_mask_t        prev_r, prev_nxt;
  logic              any_r, any_nxt;

  logic [POS_W-1:0]  pos;
  logic [IDX_W-1:0]  idx;
  logic [3:0]        id;
  logic              in_points;
  logic              press;
  logic              at_last;
  slot_mask_t        rel;

  always_comb begin
    pos       = frame_start ? '0 : byte_pos_r;
    in_points = (pos[POS_W-1:2] != '0);
    idx       = pos[POS_W-1:2] - IDX_W'(1);
    id        = report_byte[7:4];
    at_last   = (pos == LAST_POS);

    touch_cnt_nxt = touch_cnt_r;
    pt_bytes_nxt  = pt_bytes_r;
    cur_nxt       = cur_r;
    any_nxt       = any_r;
    press         = 1'b0;

    if (pos == '0) begin
      touch_cnt_nxt = (report_byte > 8'(SLOT_COUNT)) ? CNT_W'(SLOT_COUNT)
                                                     : CNT_W'(report_byte);
      cur_nxt = '0;
      any_nxt = 1'b0;
    end else if (in_points) begin
      case (pos[1:0])
        2'd0: pt_bytes_nxt[7:0]   = report_byte;
        2'd1: pt_bytes_nxt[15:8]  = report_byte;
        2'd2: pt_bytes_nxt[23:16] = report_byte;
        default: begin
          // record end: press when within count and id in range
          if ((8'(idx) < 8'(touch_cnt_r)) && (id != 4'd0) &&
              (id <= 4'(SLOT_COUNT))) begin
            press = 1'b1;
          end
        end
      endcase
    end

    cmd.press = press;
    cmd.slot  = SLOT_W'(id - 4'd1);
    cmd.x     = {pt_bytes_r[11:8], pt_bytes_r[7:0]};
    cmd.y     = {report_byte[3:0], pt_bytes_r[23:16]};
    if (press) begin
      cur_nxt = cur_nxt | (slot_mask_t'(1) << cmd.slot);
      any_nxt = 1'b1;
    end

    rel          = prev_r & ~cur_nxt;
    prev_nxt     = prev_r;
    byte_pos_nxt = pos + POS_W'(1);
    cmd.rel      = '0;
    cmd.sync     = 1'b0;
    if (at_last) begin
      cmd.rel      = rel;
      cmd.sync     = any_nxt || (rel != '0);
      any_nxt      = any_nxt || (rel != '0);
      prev_nxt     = cur_nxt;
      byte_pos_nxt = '0;
    end

    push = accept && (cmd.press || (cmd.rel != '0) || cmd.sync);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_pos_r  <= '0;
      touch_cnt_r <= '0;
      pt_bytes_r  <= '0;
      cur_r       <= '0;
      prev_r      <= '0;
      any_r       <= 1'b0;
    end else if (accept) begin
      byte_pos_r  <= byte_pos_nxt;
      touch_cnt_r <= touch_cnt_nxt;
      pt_bytes_r  <= pt_bytes_nxt;
      cur_r       <= cur_nxt;
      prev_r      <= prev_nxt;
      any_r       <= any_nxt;
    end
  end

endmodule

// ===== rtl/trst_queue.sv =====
// ----------------------------------------------------------------------------
// trst_queue
// Small register FIFO of event work between parser and event generator.
// ----------------------------------------------------------------------------
module trst_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  trst_pkg::cmd_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output trst_pkg::cmd_t head
);
  import trst_pkg::*;

  cmd_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   count_r, count_nxt;

  always_comb begin
    full       = (count_r == (QPTR_W + 1)'(QDEPTH));
    valid      = (count_r != '0);
    head       = mem_r[rd_ptr_r];
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + (QPTR_W + 1)'(push) - (QPTR_W + 1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== rtl/trst_back.sv =====
// ----------------------------------------------------------------------------
// trst_back
// Event generator: expands queued work into one event per cycle unless stalled.
// ----------------------------------------------------------------------------
module trst_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_valid,
  input  trst_pkg::cmd_t               q_head,
  output logic                         q_pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   out_kind,
  output logic [2:0]                   out_slot,
  output logic [trst_pkg::COORD_W-1:0] out_pos_x,
  output logic [trst_pkg::COORD_W-1:0] out_pos_y,
  output logic                         out_last
);
  import trst_pkg::*;

  cmd_t               work_r, work_nxt, work_left;
  logic               work_valid_r, work_valid_nxt;
  logic               out_valid_r, out_valid_nxt;
  kind_t              kind_r, kind_nxt;
  logic [SLOT_W-1:0]  slot_r, slot_nxt;
  logic [COORD_W-1:0] x_r, x_nxt, y_r, y_nxt;
  logic               last_r, last_nxt;
  logic               can_emit, emit, done;

  always_comb begin
    can_emit  = !out_valid_r || out_ready;
    emit      = can_emit && work_valid_r;
    work_left = work_r;
    kind_nxt  = kind_r;
    slot_nxt  = slot_r;
    x_nxt     = x_r;
    y_nxt     = y_r;

    // press first, then releases low slot first, then sync
    if (work_r.press) begin
      kind_nxt        = KIND_PRESS;
      slot_nxt        = work_r.slot;
      x_nxt           = work_r.x;
      y_nxt           = work_r.y;
      work_left.press = 1'b0;
    end else if (work_r.rel != '0) begin
      kind_nxt      = KIND_RELEASE;
      slot_nxt      = low_slot(work_r.rel);
      x_nxt         = '0;
      y_nxt         = '0;
      work_left.rel = drop_low(work_r.rel);
    end else begin
      kind_nxt       = KIND_SYNC;
      slot_nxt       = '0;
      x_nxt          = '0;
      y_nxt          = '0;
      work_left.sync = 1'b0;
    end
    done     = !work_left.press && (work_left.rel == '0) && !work_left.sync;
    last_nxt = done;

    if (!emit) begin
      kind_nxt = kind_r;
      slot_nxt = slot_r;
      x_nxt    = x_r;
      y_nxt    = y_r;
      last_nxt = last_r;
    end

    out_valid_nxt = emit ? 1'b1 : (can_emit ? 1'b0 : out_valid_r);

    q_pop          = q_valid && (!work_valid_r || (emit && done));
    work_nxt       = work_r;
    work_valid_nxt = work_valid_r;
    if (emit) begin
      work_nxt       = work_left;
      work_valid_nxt = !done;
    end
    if (q_pop) begin
      work_nxt       = q_head;
      work_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      work_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      work_valid_r <= work_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    work_r <= work_nxt;
    kind_r <= kind_nxt;
    slot_r <= slot_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    last_r <= last_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_kind  = kind_r;
  assign out_slot  = slot_r;
  assign out_pos_x = x_r;
  assign out_pos_y = y_r;
  assign out_last  = last_r;

`ifndef SYNTHESIS
  a_work_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    work_valid_r |-> (work_r.press || (work_r.rel != '0) || work_r.sync))
    else $error("work register holds no pending event");

  a_work_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && !done) |=> (work_valid_r && out_valid_r && !out_last))
    else $error("unfinished work lost after emit");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (q_valid && (!work_valid_r || emit)))
    else $error("queue popped while work still pending");

  a_release_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (kind_r == KIND_RELEASE)) |->
      ((8'(slot_r) < 8'(SLOT_COUNT)) && (x_r == '0) && (y_r == '0)))
    else $error("release event with bad slot or coordinates");
`endif

endmodule

// ===== rtl/touch_report_slot_tracker_top.sv =====
// ----------------------------------------------------------------------------
// touch_report_slot_tracker_top
// Turns touch controller report bytes into press, release and sync events.
// ----------------------------------------------------------------------------
// Input channel: one report byte per transfer (in_report_byte), with
// in_frame_start marking byte 0 of a report. in_ready stays high while the
// four-entry work queue has room, so a byte can be taken every cycle.
// Output channel: one event per transfer (out_kind press/release/sync,
// out_slot, out_pos_x, out_pos_y) with out_last on the final event of the
// byte that caused it. Events come from a registered output stage.
// The first event of a byte passes through the work queue, work register and
// output register; events leave one per cycle while out_ready is high.
// Throughput: one byte per cycle while the queue has room; the last byte of a
// report may cause up to SLOT_COUNT+1 events, drained one per cycle by the event
// generator when out_ready is high; the queue absorbs bursts while bytes flow.
// Reset (rst_n low, synchronous) clears the position, slot sets, queue and
// output valid. When the receiver stalls, the output register holds its
// event, the generator waits, the queue fills and in_ready then drops.
// ----------------------------------------------------------------------------
module touch_report_slot_tracker_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [7:0]                   in_report_byte,
  input  logic                         in_frame_start,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   out_kind,
  output logic [2:0]                   out_slot,
  output logic [trst_pkg::COORD_W-1:0] out_pos_x,
  output logic [trst_pkg::COORD_W-1:0] out_pos_y,
  output logic                         out_last
);
  import trst_pkg::*;

  logic  accept;
  logic  push, full, pop, q_valid;
  cmd_t  cmd, q_head;

  assign in_ready = !full;
  assign accept   = in_valid && in_ready;

  // front: parse bytes, update slot state, emit a work entry per event-causing byte
  trst_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .report_byte (in_report_byte),
    .frame_start (in_frame_start),
    .push        (push),
    .cmd         (cmd)
  );

  // decouples the parser from output stalls and event bursts
  trst_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (cmd),
    .full      (full),
    .pop       (pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  // back: expand each entry into single events
  trst_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_kind  (out_kind),
    .out_slot  (out_slot),
    .out_pos_x (out_pos_x),
    .out_pos_y (out_pos_y),
    .out_last  (out_last)
  );

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the touch report slot tracker.
// ----------------------------------------------------------------------------
// Report bytes go in one transfer at a time while a bit-accurate tracker
// model in the bench predicts the press, release and sync events. Every
// event leaving the block is checked field by field against the oldest
// prediction. Directed reports cover the count clamp, bad slot ids, points
// beyond the count, ignored header bytes, the position wrap and an early
// frame start. Random reports follow, with gaps on both sides, a long
// receiver hold-off and full-rate stretches.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import trst_pkg::*;

  localparam int POINTS      = (REPORT_BYTES - 4) / 4;
  localparam int STALL_LIMIT = 2000;  // cycles without any transfer
  localparam int SETTLE      = 20;    // cycles watched after the last event
  localparam int ITEM_TARGET = 460;

  // One expected or observed event on the output channel.
  typedef struct {
    kind_t              kind;
    logic [SLOT_W-1:0]  slot;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               last;
  } touch_event_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         in_report_byte = 8'h00;
  logic               in_frame_start = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         out_kind;
  logic [2:0]         out_slot;
  logic [COORD_W-1:0] out_pos_x;
  logic [COORD_W-1:0] out_pos_y;
  logic               out_last;

  touch_report_slot_tracker_top i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_report_byte (in_report_byte),
    .in_frame_start (in_frame_start),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_slot       (out_slot),
    .out_pos_x      (out_pos_x),
    .out_pos_y      (out_pos_y),
    .out_last       (out_last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Tracker model state, mirrors the block's own state.
  // --------------------------------------------------------------------------
  logic [POS_W-1:0] trk_pos  = '0;
  logic [CNT_W-1:0] trk_cnt  = '0;
  logic [23:0]      trk_rec  = '0;  // first three bytes of the record
  slot_mask_t       trk_cur  = '0;  // slots pressed in this report
  slot_mask_t       trk_prev = '0;  // slots pressed in the last full report
  logic             trk_any  = 1'b0;

  touch_event_t pending_events[$];  // predicted events, oldest first

  int  mismatch_cnt  = 0;
  int  bytes_sent    = 0;
  int  hold_left     = 0;  // receiver hold-off request, counted down below
  bit  in_gaps_on    = 1'b1;
  bit  out_stalls_on = 1'b1;

  logic [7:0] rpt [REPORT_BYTES];  // report under construction

  function automatic touch_event_t mk_event(kind_t k, int s, logic [COORD_W-1:0] x,
                                            logic [COORD_W-1:0] y);
    touch_event_t e;
    e.kind = k;
    e.slot = SLOT_W'(s);
    e.x    = x;
    e.y    = y;
    e.last = 1'b0;
    return e;
  endfunction

  // Advance the tracker by one accepted byte and queue the events it makes.
  task automatic track_report_byte(input logic [7:0] b, input logic fs);
    touch_event_t burst[SLOT_COUNT + 2];
    int           n;
    int           p;
    int           k;
    int           idx;
    logic [3:0]   id;
    n = 0;
    p = fs ? 0 : int'(trk_pos);
    if (p >= REPORT_BYTES) p = 0;

    if (p == 0) begin
      // header: count clamped, new report starts with an empty slot set
      trk_cnt = (b > SLOT_COUNT) ? CNT_W'(SLOT_COUNT) : CNT_W'(b);
      trk_cur = '0;
      trk_any = 1'b0;
    end else if (p >= 4) begin
      k   = (p - 4) % 4;
      idx = (p - 4) / 4;
      if (k < 3) begin
        trk_rec[8*k +: 8] = b;
      end else if (idx < int'(trk_cnt)) begin
        id = b[7:4];
        // ids outside 1..SLOT_COUNT drop the point entirely
        if (id >= 1 && id <= SLOT_COUNT) begin
          burst[n] = mk_event(KIND_PRESS, id - 1, trk_rec[11:0], {b[3:0], trk_rec[23:16]});
          n++;
          trk_cur[id - 1] = 1'b1;
          trk_any = 1'b1;
        end
      end
    end

    if (p == REPORT_BYTES - 1) begin
      // end of report: releases in rising slot order, then sync
      for (int s = 0; s < SLOT_COUNT; s++) begin
        if (trk_prev[s] && !trk_cur[s]) begin
          burst[n] = mk_event(KIND_RELEASE, s, '0, '0);
          n++;
          trk_any = 1'b1;
        end
      end
      trk_prev = trk_cur;
      if (trk_any) begin
        burst[n] = mk_event(KIND_SYNC, 0, '0, '0);
        n++;
      end
      trk_pos = '0;
    end else begin
      trk_pos = POS_W'(p + 1);
    end

    for (int i = 0; i < n; i++) begin
      burst[i].last = (i == n - 1);
      pending_events.push_back(burst[i]);
    end
  endtask

  // --------------------------------------------------------------------------
  // Sender side. Valid is held until the transfer; a random gap may come
  // first. The transfer happens at the edge where in_ready is seen high.
  // --------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b, input logic fs);
    if (in_gaps_on) begin
      while ($urandom_range(99) < 13) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid       <= 1'b1;
    in_report_byte <= b;
    in_frame_start <= fs;
    do @(posedge clk); while (!in_ready);
    track_report_byte(b, fs);
    bytes_sent++;
  endtask

  task automatic send_frame(input int len, input bit mark_start);
    for (int i = 0; i < len; i++) send_byte(rpt[i], (i == 0) && mark_start);
  endtask

  // Sender goes quiet until every predicted event has come out.
  task automatic wait_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_events.size() != 0);
  endtask

  task automatic clear_report(input logic [7:0] cnt);
    for (int i = 0; i < REPORT_BYTES; i++) rpt[i] = 8'h00;
    rpt[0] = cnt;
  endtask

  // Record layout: x low, x high nibble (top nibble unused), y low,
  // then slot id in the top nibble over the y high nibble.
  task automatic set_point(input int idx, input logic [3:0] id,
                           input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
    rpt[4 + 4*idx] = x[7:0];
    rpt[5 + 4*idx] = {4'($urandom_range(15)), x[11:8]};
    rpt[6 + 4*idx] = y[7:0];
    rpt[7 + 4*idx] = {id, y[11:8]};
  endtask

  function automatic logic [COORD_W-1:0] rand_coord();
    int r;
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 20) return '1;
    return COORD_W'($urandom);
  endfunction

  // Mostly distinct valid ids, some repeats and some out-of-range ids.
  task automatic fill_random_report();
    bit [15:0] used;
    int        n_used;
    int        id;
    int        r;
    used   = '0;
    n_used = 0;
    r      = $urandom_range(99);
    rpt[0] = (r < 80) ? 8'($urandom_range(SLOT_COUNT)) : 8'($urandom);
    for (int i = 1; i < 4; i++) rpt[i] = 8'($urandom);
    for (int i = 0; i < POINTS; i++) begin
      r = $urandom_range(99);
      if (r < 80 && n_used < SLOT_COUNT) begin
        do id = $urandom_range(1, SLOT_COUNT); while (used[id]);
        used[id] = 1'b1;
        n_used++;
      end else if (r < 90) begin
        id = $urandom_range(1, SLOT_COUNT);
      end else begin
        id = $urandom_range(1) ? 0 : $urandom_range(SLOT_COUNT + 1, 15);
      end
      set_point(i, 4'(id), rand_coord(), rand_coord());
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Oversized count is clamped; all slots pressed at coordinate extremes.
  task automatic test_press_clamp();
    clear_report(8'hFF);
    set_point(0, 4'd1, 12'h000, 12'hFFF);
    set_point(1, 4'd2, 12'hFFF, 12'h000);
    set_point(2, 4'd3, 12'hAAA, 12'h555);
    set_point(3, 4'd4, 12'h555, 12'hAAA);
    set_point(4, 4'd5, 12'hFFF, 12'hFFF);
    send_frame(REPORT_BYTES, 1'b1);
    wait_drain();
  endtask

  // Ids 0, SLOT_COUNT+1 and 15 are dropped; header bytes 1..3 are noise.
  // Slots not pressed again are released at the report end.
  task automatic test_bad_ids();
    clear_report(8'(SLOT_COUNT));
    rpt[1] = 8'hFF;
    rpt[2] = 8'h5A;
    rpt[3] = 8'hA5;
    set_point(0, 4'd0, 12'h123, 12'h456);
    set_point(1, 4'(SLOT_COUNT + 1), 12'h789, 12'hABC);
    set_point(2, 4'd3, 12'h800, 12'h001);
    set_point(3, 4'd15, 12'hFFF, 12'hFFF);
    set_point(4, 4'(SLOT_COUNT), 12'h001, 12'h800);
    send_frame(REPORT_BYTES, 1'b1);
    wait_drain();
  endtask

  // Points past the count are ignored; no frame_start, so this report
  // relies on the position wrapping back to byte 0.
  task automatic test_count_wrap();
    clear_report(8'd2);
    for (int i = 0; i < POINTS; i++) set_point(i, 4'(i % SLOT_COUNT + 1), rand_coord(),
                                               rand_coord());
    send_frame(REPORT_BYTES, 1'b0);
    wait_drain();
  endtask

  // A report cut short by a new frame_start: its press stays sent, and the
  // next report is released against the last complete one.
  task automatic test_early_start();
    clear_report(8'd3);
    set_point(0, 4'd4, 12'h321, 12'h654);
    send_frame(10, 1'b1);
    clear_report(8'd0);
    set_point(0, 4'd1, 12'h111, 12'h222);
    send_frame(REPORT_BYTES, 1'b1);
    // nothing pressed and nothing held over: the report makes no event
    clear_report(8'd1);
    set_point(0, 4'd0, 12'hFFF, 12'hFFF);
    send_frame(REPORT_BYTES, 1'b1);
    wait_drain();
  endtask

  // Full rate on both sides.
  task automatic test_back_to_back();
    in_gaps_on    = 1'b0;
    out_stalls_on = 1'b0;
    repeat (4) begin
      fill_random_report();
      send_frame(REPORT_BYTES, 1'b1);
    end
    wait_drain();
    in_gaps_on    = 1'b1;
    out_stalls_on = 1'b1;
  endtask

  // Receiver holds off while busy reports keep coming: the work queue
  // fills and in_ready has to drop.
  task automatic test_backpressure();
    hold_left = 150;
    repeat (2) begin
      fill_random_report();
      rpt[0] = 8'(SLOT_COUNT);
      for (int i = 0; i < POINTS; i++) set_point(i, 4'(i + 1), rand_coord(), rand_coord());
      send_frame(REPORT_BYTES, 1'b1);
    end
    wait_drain();
  endtask

  // Mostly well-formed reports, some cut short, some stray bytes.
  task automatic test_random_reports();
    int r;
    while (bytes_sent < ITEM_TARGET) begin
      r = $urandom_range(99);
      fill_random_report();
      if (r < 80) begin
        send_frame(REPORT_BYTES, $urandom_range(99) < 75);
      end else if (r < 90) begin
        send_frame($urandom_range(1, REPORT_BYTES - 1), 1'b1);
      end else begin
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom), 1'($urandom_range(1)));
      end
      // occasionally let the sender pause until the output is empty
      if ($urandom_range(99) < 10) wait_drain();
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random stalls, plus a hold-off counted down here.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= !(out_stalls_on && $urandom_range(99) < 13);
    end
  end

  // Event checker: each transfer is matched against the oldest prediction.
  always @(posedge clk) begin
    touch_event_t exp_ev;
    if (rst_n && out_valid && out_ready) begin
      if (pending_events.size() == 0) begin
        $error("unexpected event: kind %0d slot %0d x %0d y %0d", out_kind, out_slot,
               out_pos_x, out_pos_y);
        mismatch_cnt++;
      end else begin
        exp_ev = pending_events.pop_front();
        if (out_kind !== exp_ev.kind) begin
          $error("kind: expected %0d, got %0d", exp_ev.kind, out_kind);
          mismatch_cnt++;
        end
        if (out_slot !== exp_ev.slot) begin
          $error("slot: expected %0d, got %0d", exp_ev.slot, out_slot);
          mismatch_cnt++;
        end
        if (out_pos_x !== exp_ev.x) begin
          $error("pos_x: expected %0d, got %0d", exp_ev.x, out_pos_x);
          mismatch_cnt++;
        end
        if (out_pos_y !== exp_ev.y) begin
          $error("pos_y: expected %0d, got %0d", exp_ev.y, out_pos_y);
          mismatch_cnt++;
        end
        if (out_last !== exp_ev.last) begin
          $error("last: expected %0d, got %0d", exp_ev.last, out_last);
          mismatch_cnt++;
        end
      end
    end
  end

  // Watchdog: too long without a transfer on either channel ends the run.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_press_clamp();
    test_bad_ids();
    test_count_wrap();
    test_early_start();
    test_back_to_back();
    test_backpressure();
    test_random_reports();

    // drain, then keep watching for stray events
    wait_drain();
    repeat (SETTLE) @(posedge clk);
    if (mismatch_cnt == 0 && pending_events.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
